[sv/hdrtm_pkg.sv]
// ----------------------------------------------------------------------------
// hdrtm_pkg
// Shared types, the tone curve arithmetic and the threshold table built from
// it when the design is elaborated.
// ----------------------------------------------------------------------------
package hdrtm_pkg;

  localparam int unsigned SEARCH_STEPS = 8;
  localparam int unsigned LOG_FRAC = 44;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
  localparam logic [63:0] Q62_ONE = 64'h4000000000000000;

  // A key above every positive finite half; marks a level that is never reached.
  localparam logic [14:0] KEY_NEVER = 15'h7C00;

  typedef logic [14:0] key_t;
  typedef logic [7:0] level_t;
  typedef key_t thr_tab_t [256];

  // Work carried down the search pipeline for one channel.
  typedef struct packed {
    key_t   key;
    level_t acc;
    logic   force_max;
    logic   force_zero;
  } srch_t;

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    pr = pr >> s;
    return pr[63:0];
  endfunction

  function automatic logic [63:0] log2_int(logic [63:0] p);
    int unsigned n;
    int unsigned i;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] frac;
    n = 0;
    frac = '0;
    if (p == 64'd0) return 64'd0;
    t = p;
    while (t > 64'd1) begin
      t = t >> 1;
      n++;
    end
    y = (n <= 62) ? (p << (62 - n)) : (p >> (n - 62));
    for (i = 1; i <= LOG_FRAC; i++) begin
      y = mul_shr(y, y, 62);
      if (y[63]) begin
        y = y >> 1;
        frac[LOG_FRAC - i] = 1'b1;
      end
    end
    return (64'(n) << LOG_FRAC) | frac;
  endfunction

  function automatic logic [63:0] exp2_frac(logic [63:0] f);
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned n;
    z = mul_shr(f << 18, LN2_Q64, 64);
    sum = Q62_ONE;
    term = Q62_ONE;
    for (n = 1; n <= 24; n++) begin
      term = mul_shr(term, z, 62) / 64'(n);
      sum = sum + term;
    end
    return sum;
  endfunction

  // Full curve for one positive finite half (sign clear, exponent below 31).
  function automatic level_t tone_of(logic [14:0] h);
    logic [4:0] ex;
    logic [63:0] m, p, q, rm, v40, d, kd, u40, ln, dv, w, mag, r, lu_pos;
    int e;
    int unsigned s, n;
    logic above;
    longint lv, g, t, lu, one;
    ex = h[14:10];
    one = longint'(64'd1 << LOG_FRAC);
    if (ex == 5'd0) begin
      m = 64'(h[9:0]);
      e = -24;
    end else begin
      m = 64'(h[9:0]) | 64'd1024;
      e = int'(ex) - 25;
    end
    if (m == 64'd0) return 8'd0;
    p = m * 64'd555555;
    if (e >= 0) above = (p << e) > 64'd100000;
    else above = p > (64'd100000 << (-e));
    if (!above) begin
      lv = longint'(log2_int(p)) + longint'(e) * one - longint'(log2_int(64'd100000));
    end else begin
      s = unsigned'(e + 40);
      q = p / 64'd100000;
      rm = p % 64'd100000;
      v40 = (q << s) + ((rm << s) / 64'd100000);
      d = v40 - (64'd1 << 40);
      kd = (d / 64'd1000000) * 64'd184874 + ((d % 64'd1000000) * 64'd184874) / 64'd1000000;
      u40 = (64'd1 << 40) + kd;
      lu = longint'(log2_int(u40)) - 40 * one;
      lu_pos = (lu < 0) ? 64'd0 : 64'(lu);
      ln = mul_shr(lu_pos, LN2_Q64, 64);
      dv = (ln / 64'd184874) * 64'd1000000 + ((ln % 64'd184874) * 64'd1000000) / 64'd184874;
      w = 64'(one) + dv;
      lv = longint'(log2_int(w)) - 44 * one;
    end
    mag = (lv < 0) ? (64'd0 - 64'(lv)) : 64'(lv);
    mag = mag * 64'd4545 / 64'd10000;
    g = (lv < 0) ? -longint'(mag) : longint'(mag);
    t = g + longint'(log2_int(64'd8466)) - longint'(log2_int(64'd100));
    if (t < 0) return 8'd0;
    if (t >= 8 * one) return 8'd255;
    n = 32'(t >>> LOG_FRAC);
    r = exp2_frac(64'(t) & (64'(one) - 64'd1));
    r = r >> (62 - n);
    return (r > 64'd255) ? 8'd255 : r[7:0];
  endfunction

  // Entry k, for k from 1, holds the smallest positive finite half whose byte is at least k; entry 0 is zero.
  function automatic thr_tab_t build_thresholds();
    thr_tab_t tab;
    int unsigned k;
    int unsigned lo, hi, mid;
    tab[0] = '0;
    for (k = 1; k < 256; k++) begin
      lo = 1;
      hi = 32'(KEY_NEVER);
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (32'(tone_of(15'(mid))) >= k) hi = mid;
        else lo = mid + 1;
      end
      tab[k] = 15'(lo);
    end
    return tab;
  endfunction

  localparam thr_tab_t THRESH = build_thresholds();

endpackage

[sv/hdrtm_search_stage.sv]
// ----------------------------------------------------------------------------
// hdrtm_search_stage
// One registered step of the binary search over the threshold table.
// ----------------------------------------------------------------------------
module hdrtm_search_stage (
  input  logic                   clk,
  input  hdrtm_pkg::level_t      probe,
  input  hdrtm_pkg::srch_t       cur,
  output hdrtm_pkg::srch_t       nxt
);
  import hdrtm_pkg::*;

  level_t cand;
  srch_t  nxt_next;

  always_comb begin
    cand = cur.acc | probe;
    nxt_next = cur;
    if (THRESH[cand] <= cur.key) nxt_next.acc = cand;
  end

  always_ff @(posedge clk) begin
    nxt <= nxt_next;
  end

endmodule

[sv/hdrtm_channel.sv]
// ----------------------------------------------------------------------------
// hdrtm_channel
// One channel: classifies the half, searches its byte in eight stages and
// registers the result.
// ----------------------------------------------------------------------------
module hdrtm_channel (
  input  logic              clk,
  input  logic              load,
  input  logic [15:0]       half,
  output hdrtm_pkg::level_t byte_out
);
  import hdrtm_pkg::*;

  srch_t  pipe [SEARCH_STEPS + 1];
  srch_t  entry_next;
  level_t byte_next;

  always_comb begin
    entry_next.key = half[14:0];
    entry_next.acc = '0;
    entry_next.force_max = 1'b0;
    entry_next.force_zero = 1'b0;
    if (half[14:10] == 5'h1F) begin
      // Positive infinity saturates; negative infinity and NaN of either sign read as black.
      entry_next.force_max = (half[9:0] == 10'd0) && !half[15];
      entry_next.force_zero = !((half[9:0] == 10'd0) && !half[15]);
    end else if (half[15] || (half[14:0] == 15'd0)) begin
      entry_next.force_zero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) pipe[0] <= entry_next;
  end

  for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
    hdrtm_search_stage u_step (
      .clk   (clk),
      .probe (level_t'(1 << (SEARCH_STEPS - 1 - i))),
      .cur   (pipe[i]),
      .nxt   (pipe[i + 1])
    );
  end

  always_comb begin
    if (pipe[SEARCH_STEPS].force_max) byte_next = '1;
    else if (pipe[SEARCH_STEPS].force_zero) byte_next = '0;
    else byte_next = pipe[SEARCH_STEPS].acc;
  end

  always_ff @(posedge clk) begin
    byte_out <= byte_next;
  end

endmodule

[sv/hdr_half_to_rgba8_tonemap.sv]
// ----------------------------------------------------------------------------
// hdr_half_to_rgba8_tonemap
// Four half-float channels in, four tone-mapped bytes out, one pixel a clock.
// ----------------------------------------------------------------------------
// A request is taken on every clock in which start is high; busy never rises.
// Each pixel comes back on the byte ports with done high for a single
// cycle, and the receiver cannot hold it off. On its way it passes one input
// register, eight stages of a binary search over a 256-entry threshold table
// of the curve, and one output register. All four channels, alpha included,
// follow the same curve.
module hdr_half_to_rgba8_tonemap (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] red_half,
  input  logic [15:0] green_half,
  input  logic [15:0] blue_half,
  input  logic [15:0] alpha_half,
  output logic        done,
  output logic [7:0]  red_byte,
  output logic [7:0]  green_byte,
  output logic [7:0]  blue_byte,
  output logic [7:0]  alpha_byte
);
  import hdrtm_pkg::*;

  localparam int unsigned DEPTH = SEARCH_STEPS + 2;

  logic [DEPTH-1:0] vld;
  logic             load;

  assign busy = 1'b0;
  assign load = start && !busy;
  assign done = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], load};
    end
  end

  hdrtm_channel u_red   (.clk(clk), .load(load), .half(red_half),   .byte_out(red_byte));
  hdrtm_channel u_green (.clk(clk), .load(load), .half(green_half), .byte_out(green_byte));
  hdrtm_channel u_blue  (.clk(clk), .load(load), .half(blue_half),  .byte_out(blue_byte));
  hdrtm_channel u_alpha (.clk(clk), .load(load), .half(alpha_half), .byte_out(alpha_byte));

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, DEPTH)) else $error("done without a matching request");

  a_inf_saturates: assert property (@(posedge clk) disable iff (rst)
    (start && red_half == 16'h7C00) |-> ##DEPTH (done && red_byte == 8'hFF))
    else $error("positive infinity did not give full scale");

  a_negative_black: assert property (@(posedge clk) disable iff (rst)
    (start && green_half[15]) |-> ##DEPTH (done && green_byte == 8'h00))
    else $error("negative input did not give zero");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Tests the half-float to RGBA8 tone mapper. Each pixel request is run through
// a bit-exact fixed-point copy of the curve, and every strobed result is
// compared channel by channel with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

typedef struct {
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] a;
} rgba8_t;

class tonemap_scoreboard;
  rgba8_t pending_q[$];
  int     errors;

  function automatic logic [63:0] mul_hi_shift(logic [63:0] x, logic [63:0] y,
                                               int unsigned sh);
    logic [127:0] pr;
    pr = {64'd0, x} * {64'd0, y};
    pr = pr >> sh;
    return pr[63:0];
  endfunction

  // Base-2 logarithm of a positive integer in Q44, by repeated squaring.
  function automatic logic [63:0] lg2_q44(logic [63:0] v);
    int unsigned msb;
    int unsigned i;
    logic [63:0] y;
    logic [63:0] fr;
    msb = 0;
    fr = '0;
    if (v == 64'd0) return 64'd0;
    for (i = 0; i < 64; i++) if (v[i]) msb = i;
    y = (msb <= 62) ? (v << (62 - msb)) : (v >> (msb - 62));
    for (i = 1; i <= 44; i++) begin
      y = mul_hi_shift(y, y, 62);
      if (y[63]) begin
        y = y >> 1;
        fr[44 - i] = 1'b1;
      end
    end
    return (64'(msb) << 44) | fr;
  endfunction

  // 2^f for a Q44 fraction, as a Q62 value from a truncated Taylor series.
  function automatic logic [63:0] pow2_frac_q62(logic [63:0] f);
    logic [63:0] z;
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned k;
    z = mul_hi_shift(f << 18, 64'hB17217F7D1CF79AB, 64);
    acc = 64'h4000000000000000;
    term = acc;
    for (k = 1; k <= 24; k++) begin
      term = mul_hi_shift(term, z, 62) / 64'(k);
      acc = acc + term;
    end
    return acc;
  endfunction

  function automatic logic [7:0] channel_byte(logic [15:0] h);
    logic [4:0] ex;
    logic [63:0] m, p, q, rm, v40, d, kd, u40, ln, dv, w, mag, r, lu_pos;
    int ee;
    int unsigned n;
    logic above;
    longint lv, g, t, lu, one;
    one = longint'(64'd1 << 44);
    ex = h[14:10];
    if (ex == 5'd31) return (h[9:0] == 10'd0 && !h[15]) ? 8'd255 : 8'd0;
    if (h[15] || h[14:0] == 15'd0) return 8'd0;
    if (ex == 5'd0) begin
      m = 64'(h[9:0]);
      ee = -24;
    end else begin
      m = 64'(h[9:0]) | 64'd1024;
      ee = int'(ex) - 25;
    end
    p = m * 64'd555555;
    if (ee >= 0) above = (p << unsigned'(ee)) > 64'd100000;
    else above = p > (64'd100000 << unsigned'(-ee));
    if (!above) begin
      lv = longint'(lg2_q44(p)) + longint'(ee) * one - longint'(lg2_q44(64'd100000));
    end else begin
      q = p / 64'd100000;
      rm = p % 64'd100000;
      v40 = (q << unsigned'(ee + 40)) + ((rm << unsigned'(ee + 40)) / 64'd100000);
      d = v40 - (64'd1 << 40);
      kd = (d / 64'd1000000) * 64'd184874 + ((d % 64'd1000000) * 64'd184874) / 64'd1000000;
      u40 = (64'd1 << 40) + kd;
      lu = longint'(lg2_q44(u40)) - 40 * one;
      lu_pos = (lu < 0) ? 64'd0 : 64'(lu);
      ln = mul_hi_shift(lu_pos, 64'hB17217F7D1CF79AB, 64);
      dv = (ln / 64'd184874) * 64'd1000000 + ((ln % 64'd184874) * 64'd1000000) / 64'd184874;
      w = 64'(one) + dv;
      lv = longint'(lg2_q44(w)) - 44 * one;
    end
    mag = (lv < 0) ? (64'd0 - 64'(lv)) : 64'(lv);
    mag = mag * 64'd4545 / 64'd10000;
    g = (lv < 0) ? -longint'(mag) : longint'(mag);
    t = g + longint'(lg2_q44(64'd8466)) - longint'(lg2_q44(64'd100));
    if (t < 0) return 8'd0;
    if (t >= 8 * one) return 8'd255;
    n = 32'(t >>> 44);
    r = pow2_frac_q62(64'(t) & (64'(one) - 64'd1));
    r = r >> (62 - n);
    return (r > 64'd255) ? 8'd255 : r[7:0];
  endfunction

  function void note_request(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic [15:0] a);
    rgba8_t px;
    px.r = channel_byte(r);
    px.g = channel_byte(g);
    px.b = channel_byte(b);
    px.a = channel_byte(a);
    pending_q.push_back(px);
  endfunction

  function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    rgba8_t px;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected pixel %h %h %h %h", $time, r, g, b, a);
      errors++;
      return;
    end
    px = pending_q.pop_front();
    if (px.r !== r) begin
      $display("%0t: red expected %h actual %h", $time, px.r, r);
      errors++;
    end
    if (px.g !== g) begin
      $display("%0t: green expected %h actual %h", $time, px.g, g);
      errors++;
    end
    if (px.b !== b) begin
      $display("%0t: blue expected %h actual %h", $time, px.b, b);
      errors++;
    end
    if (px.a !== a) begin
      $display("%0t: alpha expected %h actual %h", $time, px.a, a);
      errors++;
    end
  endfunction
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] red_half = '0;
  logic [15:0] green_half = '0;
  logic [15:0] blue_half = '0;
  logic [15:0] alpha_half = '0;
  logic        done;
  logic [7:0]  red_byte;
  logic [7:0]  green_byte;
  logic [7:0]  blue_byte;
  logic [7:0]  alpha_byte;

  tonemap_scoreboard sb = new();

  logic [15:0] corner_vals[16] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                   16'hFE01, 16'h0001, 16'h03FF, 16'h0400, 16'h3C00,
                                   16'h31C7, 16'h31C8, 16'h7BFF, 16'hFBFF, 16'h7FFF,
                                   16'h4900};
  int idle_pct[4] = '{0, 77, 0, 33};

  hdr_half_to_rgba8_tonemap DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_request(red_half, green_half, blue_half, alpha_half);
    if (!rst && done)
      sb.check_pixel(red_byte, green_byte, blue_byte, alpha_byte);
  end

  task automatic drive_pixel(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic [15:0] a, input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    red_half <= r;
    green_half <= g;
    blue_half <= b;
    alpha_half <= a;
    do @(posedge clk); while (busy);
  endtask

  // Mostly positive finite values across the useful exponent range, since
  // random bit patterns land on saturated or zero bytes too often.
  function automatic logic [15:0] random_half();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return 16'($urandom);
    if (sel < 90) return {1'b0, 5'($urandom_range(22)), 10'($urandom)};
    return corner_vals[$urandom_range(15)];
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 16; i++)
      drive_pixel(corner_vals[i], corner_vals[(i + 5) % 16], corner_vals[(i + 9) % 16],
                  corner_vals[15 - i], 0);
    for (int ph = 0; ph < 4; ph++)
      for (int i = 0; i < 150; i++)
        drive_pixel(random_half(), random_half(), random_half(), random_half(),
                    idle_pct[ph]);
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
